@@ hdl/kpp_pkg.sv @@
// Package: shared types, register indexes and constants of the position predictor.
`timescale 1ns / 1ps
`default_nettype none
package kpp_pkg;

  localparam int FRAC = 24;

  typedef enum logic [2:0] {
    REG_STEP_TIME = 3'd0,
    REG_GRAV_X    = 3'd1,
    REG_GRAV_Y    = 3'd2,
    REG_GRAV_Z    = 3'd3,
    REG_Q_POS     = 3'd4,
    REG_Q_VEL     = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DT2,
    ST_ROT,
    ST_GRAV,
    ST_POS_V,
    ST_POS_A,
    ST_VEL,
    ST_COV_T,
    ST_COV_P,
    ST_COV_Q,
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Request to the shared multiply unit: floor(a*b / 2^shift), saturated.
  typedef struct packed {
    logic               start;
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
    logic [4:0]         shift;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] prod;
  } mul_rsp_t;

  // Saturating signed 64 bit add.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/kpp_stream_if.sv @@
// Interfaces: valid/ready channels for input words, result words and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface kpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] accel_z;
  logic signed [31:0] att_00;
  logic signed [31:0] att_01;
  logic signed [31:0] att_02;
  logic signed [31:0] att_10;
  logic signed [31:0] att_11;
  logic signed [31:0] att_12;
  logic signed [31:0] att_20;
  logic signed [31:0] att_21;
  logic signed [31:0] att_22;
  modport source (output valid, accel_x, accel_y, accel_z, att_00, att_01, att_02,
                  att_10, att_11, att_12, att_20, att_21, att_22, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, att_00, att_01, att_02,
                att_10, att_11, att_12, att_20, att_21, att_22, output ready);
endinterface

interface kpp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         row_index;
  logic signed [63:0] state_value;
  logic signed [63:0] cov_c0;
  logic signed [63:0] cov_c1;
  logic signed [63:0] cov_c2;
  logic signed [63:0] cov_c3;
  logic signed [63:0] cov_c4;
  logic signed [63:0] cov_c5;
  logic               last_row;
  modport source (output valid, row_index, state_value, cov_c0, cov_c1, cov_c2, cov_c3,
                  cov_c4, cov_c5, last_row, input ready);
  modport sink (input valid, row_index, state_value, cov_c0, cov_c1, cov_c2, cov_c3,
                cov_c4, cov_c5, last_row, output ready);
endinterface

interface kpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/kpp_mul_unit.sv @@
// Shared multiplier: 64x64 signed product from 32x32 partial products, shift, saturate.
`timescale 1ns / 1ps
`default_nettype none
module kpp_mul_unit
  import kpp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [4:0]   shift_r;
  logic [1:0]   pp_cnt_r, pp_cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         fin_r, fin_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  pp_r;
  logic [6:0]   pp_pos_r;
  logic         pp_vld_r;
  logic [31:0]  sel_a, sel_b;
  logic         done_r;
  logic signed [63:0] prod_r, prod_nxt;

  logic [127:0] shifted;
  logic         rem;
  logic [127:0] mag_q;
  logic [63:0]  mag_a, mag_b;

  assign mag_a = req.op_a[63] ? 64'(-req.op_a) : req.op_a;
  assign mag_b = req.op_b[63] ? 64'(-req.op_b) : req.op_b;

  // Select one 32x32 partial product per cycle
  always_comb begin
    sel_a = pp_cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
    sel_b = pp_cnt_r[0] ? ub_r[63:32] : ub_r[31:0];
  end

  always_comb begin
    busy_nxt   = busy_r;
    pp_cnt_nxt = pp_cnt_r;
    fin_nxt    = 1'b0;
    acc_nxt    = acc_r;
    if (pp_vld_r) begin
      acc_nxt = acc_r + ({64'd0, pp_r} << pp_pos_r);
    end
    if (req.start) begin
      busy_nxt   = 1'b1;
      pp_cnt_nxt = 2'd0;
      acc_nxt    = '0;
    end else if (busy_r) begin
      pp_cnt_nxt = pp_cnt_r + 2'd1;
      if (pp_cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
      end
    end
    if (pp_vld_r && !busy_r) begin
      fin_nxt = 1'b1;
    end
  end

  // Shift by fraction bits, round toward minus infinity, saturate
  always_comb begin
    shifted  = acc_r >> shift_r;
    rem      = (acc_r & ((128'd1 << shift_r) - 128'd1)) != 128'd0;
    mag_q    = shifted + {127'd0, neg_r & rem};
    if (!neg_r) begin
      prod_nxt = (mag_q[127:63] != '0) ? {1'b0, {63{1'b1}}} : mag_q[63:0];
    end else if (mag_q[127:64] != '0 || mag_q[63:0] > {1'b1, 63'd0}) begin
      prod_nxt = {1'b1, 63'd0};
    end else begin
      prod_nxt = 64'(-mag_q[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pp_cnt_r <= 2'd0;
      pp_vld_r <= 1'b0;
      fin_r    <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      pp_cnt_r <= pp_cnt_nxt;
      pp_vld_r <= busy_r;
      fin_r    <= fin_nxt;
      done_r   <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua_r    <= mag_a;
      ub_r    <= mag_b;
      neg_r   <= req.op_a[63] ^ req.op_b[63];
      shift_r <= req.shift;
    end
    pp_r     <= sel_a * sel_b;
    pp_pos_r <= {pp_cnt_r[1], 5'd0} + {pp_cnt_r[0], 5'd0};
    acc_r    <= acc_nxt;
    if (fin_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule
`default_nettype wire

@@ hdl/kalman_position_predict.sv @@
// Top level: six-state Kalman prediction driven by a sequencer around one multiplier.
// Sequencing: each covariance product waits for the store read of its address before it
//   starts; after the products the result rows are loaded from the store one at a time.
// Input: a new word is taken only in idle, after the 55 serial products through the
//   single shared multiplier, the row loads and the emit of all six rows.
// Reset: rst_n synchronous; sequencer, counters, config, pos and vel clear to zero,
//   then a pass over the 36 entries clears the covariance store; in_ch.ready stays low.
`timescale 1ns / 1ps
`default_nettype none
module kalman_position_predict
  import kpp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  kpp_in_if.sink    in_ch,
  kpp_out_if.source out_ch,
  kpp_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic [31:0]        step_time_r;
  logic signed [31:0] grav_r [3];
  logic [47:0]        q_pos_r, q_vel_r;

  // captured input word
  logic signed [31:0] acc_r [3];
  logic signed [31:0] att_r [9];

  // filter state
  logic signed [63:0] pos_r [3];
  logic signed [63:0] vel_r [3];
  logic signed [63:0] cov_r [36];
  logic signed [63:0] a_r   [3];
  logic signed [63:0] dt2_r;

  // covariance store ports and the row being presented
  logic signed [63:0] rd_a_r, rd_b_r;
  logic               rd_fresh_r;
  logic [5:0]         rd_a_addr, rd_b_addr, wr_addr;
  logic               wr_en;
  logic signed [63:0] wr_data;
  logic signed [63:0] row_buf_r [6];

  state_t      state_r, state_nxt;
  logic [2:0]  i_r, j_r;
  logic [5:0]  idx_r;
  logic        wait_r;
  logic [2:0]  row_r;

  mul_req_t req;
  mul_rsp_t rsp;

  kpp_mul_unit u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic signed [63:0] dt;
  assign dt = {32'd0, step_time_r};

  logic [5:0] idx_plus3, idx_plus18;
  assign idx_plus3  = idx_r + 6'd3;
  assign idx_plus18 = idx_r + 6'd18;

  logic [3:0] att_sel;
  assign att_sel = 4'({1'b0, j_r} * 4'd3 + {1'b0, i_r});

  logic [5:0] rbase, diag_addr, ld_addr;
  assign rbase     = 6'(row_r) * 6'd6;
  assign diag_addr = 6'(i_r) * 6'd7;
  assign ld_addr   = rbase + ((j_r > 3'd5) ? 6'd5 : 6'(j_r));

  // Drive the shared multiplier operands from the step being run
  always_comb begin
    req.start = 1'b0;
    req.op_a  = '0;
    req.op_b  = dt;
    req.shift = 5'(FRAC);
    unique case (state_r)
      ST_DT2: begin
        req.op_a = dt;
      end
      ST_ROT: begin
        req.op_a  = 64'(att_r[att_sel]);
        req.op_b  = 64'(acc_r[j_r[1:0]]);
        req.shift = 5'd22;
      end
      ST_POS_V: begin
        req.op_a = vel_r[i_r[1:0]];
      end
      ST_POS_A: begin
        req.op_a = a_r[i_r[1:0]];
        req.op_b = dt2_r;
      end
      ST_VEL: begin
        req.op_a = a_r[i_r[1:0]];
      end
      ST_COV_T: begin
        req.op_a = rd_a_r;
      end
      ST_COV_P: begin
        req.op_a = rd_a_r;
      end
      default: begin
      end
    endcase
    // covariance products wait for the store read of the new address
    if (!wait_r && (state_r == ST_DT2 || state_r == ST_ROT || state_r == ST_POS_V ||
        state_r == ST_POS_A || state_r == ST_VEL ||
        ((state_r == ST_COV_T || state_r == ST_COV_P) && rd_fresh_r))) begin
      req.start = 1'b1;
    end
  end

  // Covariance store addresses and write port
  always_comb begin
    rd_a_addr = idx_r;
    rd_b_addr = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_COV_T: begin
        rd_a_addr = idx_plus3;
        if (rsp.done) begin
          wr_en   = 1'b1;
          wr_data = sat_add(rd_b_r, rsp.prod);
        end
      end
      ST_COV_P: begin
        rd_a_addr = idx_plus18;
        if (rsp.done) begin
          wr_en   = 1'b1;
          wr_data = sat_add(rd_b_r, rsp.prod);
        end
      end
      ST_COV_Q: begin
        rd_b_addr = diag_addr;
        wr_addr   = diag_addr;
        if (j_r[0]) begin
          wr_en   = 1'b1;
          wr_data = sat_add(rd_b_r, (i_r < 3'd3) ? {16'd0, q_pos_r} : {16'd0, q_vel_r});
        end
      end
      ST_LOAD: begin
        rd_a_addr = ld_addr;
      end
      default: begin
      end
    endcase
  end

  // Write and read the covariance store
  always_ff @(posedge clk) begin
    if (wr_en) cov_r[wr_addr] <= wr_data;
    rd_a_r <= cov_r[rd_a_addr];
    rd_b_r <= cov_r[rd_b_addr];
  end

  logic accept_in, emit_go;
  assign accept_in = in_ch.valid && in_ch.ready;
  assign emit_go   = out_ch.valid && out_ch.ready;

  // Next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (idx_r == 6'd35) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept_in) state_nxt = ST_DT2;
      ST_DT2:   if (rsp.done) state_nxt = ST_ROT;
      ST_ROT:   if (rsp.done && j_r == 3'd2) state_nxt = ST_GRAV;
      ST_GRAV:  if (i_r == 3'd2) state_nxt = ST_POS_V;
                else state_nxt = ST_ROT;
      ST_POS_V: if (rsp.done) state_nxt = ST_POS_A;
      ST_POS_A: if (rsp.done) state_nxt = ST_VEL;
      ST_VEL:   if (rsp.done) state_nxt = (i_r == 3'd2) ? ST_COV_T : ST_POS_V;
      ST_COV_T: if (rsp.done && idx_r == 6'd32) state_nxt = ST_COV_P;
      ST_COV_P: if (rsp.done && idx_r == 6'd17) state_nxt = ST_COV_Q;
      ST_COV_Q: if (j_r[0] && i_r == 3'd5) state_nxt = ST_LOAD;
      ST_LOAD:  if (j_r == 3'd6) state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_go) state_nxt = (row_r == 3'd5) ? ST_IDLE : ST_LOAD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer counters and datapath updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r      <= 1'b0;
      rd_fresh_r  <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      idx_r       <= '0;
      row_r       <= '0;
      step_time_r <= '0;
      q_pos_r     <= '0;
      q_vel_r     <= '0;
      for (int k = 0; k < 3; k++) begin
        grav_r[k] <= '0;
        pos_r[k]  <= '0;
        vel_r[k]  <= '0;
      end
    end else begin
      if (req.start) wait_r <= 1'b1;
      if (rsp.done) wait_r <= 1'b0;
      rd_fresh_r <= !rsp.done;

      // take a register write word
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_STEP_TIME: step_time_r <= cfg_ch.data[31:0];
          REG_GRAV_X:    grav_r[0]   <= cfg_ch.data[31:0];
          REG_GRAV_Y:    grav_r[1]   <= cfg_ch.data[31:0];
          REG_GRAV_Z:    grav_r[2]   <= cfg_ch.data[31:0];
          REG_Q_POS:     q_pos_r     <= cfg_ch.data[47:0];
          REG_Q_VEL:     q_vel_r     <= cfg_ch.data[47:0];
          default: begin
          end
        endcase
      end

      unique case (state_r)
        // walk the store once, writing zeros
        ST_CLEAR: idx_r <= (idx_r == 6'd35) ? 6'd0 : idx_r + 6'd1;
        ST_IDLE: begin
          i_r <= '0; j_r <= '0; idx_r <= '0; row_r <= '0;
          if (accept_in) begin
            acc_r[0] <= in_ch.accel_x; acc_r[1] <= in_ch.accel_y;
            acc_r[2] <= in_ch.accel_z;
            att_r[0] <= in_ch.att_00; att_r[1] <= in_ch.att_01; att_r[2] <= in_ch.att_02;
            att_r[3] <= in_ch.att_10; att_r[4] <= in_ch.att_11; att_r[5] <= in_ch.att_12;
            att_r[6] <= in_ch.att_20; att_r[7] <= in_ch.att_21; att_r[8] <= in_ch.att_22;
            for (int k = 0; k < 3; k++) a_r[k] <= '0;
          end
        end
        ST_DT2: if (rsp.done) dt2_r <= rsp.prod;
        ST_ROT: if (rsp.done) begin
          a_r[i_r[1:0]] <= sat_add(a_r[i_r[1:0]], rsp.prod);
          j_r <= (j_r == 3'd2) ? 3'd0 : j_r + 3'd1;
        end
        ST_GRAV: begin
          a_r[i_r[1:0]] <= sat_add(a_r[i_r[1:0]], 64'(grav_r[i_r[1:0]]));
          i_r <= (i_r == 3'd2) ? 3'd0 : i_r + 3'd1;
        end
        ST_POS_V: if (rsp.done) pos_r[i_r[1:0]] <= sat_add(pos_r[i_r[1:0]], rsp.prod);
        ST_POS_A: if (rsp.done) pos_r[i_r[1:0]] <= sat_add(pos_r[i_r[1:0]], rsp.prod);
        ST_VEL: if (rsp.done) begin
          vel_r[i_r[1:0]] <= sat_add(vel_r[i_r[1:0]], rsp.prod);
          i_r <= (i_r == 3'd2) ? 3'd0 : i_r + 3'd1;
        end
        // T = P * Phi^T in place: columns 0..2 of each row gain dt times column c+3
        ST_COV_T: if (rsp.done) begin
          if (idx_r == 6'd32) begin
            idx_r <= '0;
            j_r   <= '0;
          end else if (j_r == 3'd2) begin
            idx_r <= idx_r + 6'd4;
            j_r   <= '0;
          end else begin
            idx_r <= idx_r + 6'd1;
            j_r   <= j_r + 3'd1;
          end
        end
        // P = Phi * T in place: rows 0..2 gain dt times row r+3
        ST_COV_P: if (rsp.done) begin
          idx_r <= (idx_r == 6'd17) ? 6'd0 : idx_r + 6'd1;
        end
        // read a diagonal entry, then add Q to it; the six entries in turn
        ST_COV_Q: begin
          if (j_r[0]) begin
            i_r <= (i_r == 3'd5) ? 3'd0 : i_r + 3'd1;
            j_r <= '0;
          end else begin
            j_r <= 3'd1;
          end
        end
        // gather one covariance row from the store
        ST_LOAD: begin
          if (j_r != 3'd0) row_buf_r[j_r - 3'd1] <= rd_a_r;
          j_r <= (j_r == 3'd6) ? 3'd0 : j_r + 3'd1;
        end
        ST_EMIT: if (emit_go) row_r <= row_r + 3'd1;
        default: begin
        end
      endcase
    end
  end

  // Present one result row per word
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == ST_EMIT);
  assign out_ch.row_index   = row_r;
  assign out_ch.state_value = (row_r < 3'd3) ? pos_r[row_r[1:0]] : vel_r[2'(row_r - 3'd3)];
  assign out_ch.cov_c0 = row_buf_r[0];
  assign out_ch.cov_c1 = row_buf_r[1];
  assign out_ch.cov_c2 = row_buf_r[2];
  assign out_ch.cov_c3 = row_buf_r[3];
  assign out_ch.cov_c4 = row_buf_r[4];
  assign out_ch.cov_c5 = row_buf_r[5];
  assign out_ch.last_row = (row_r == 3'd5);

endmodule
`default_nettype wire
